// ===== hdl/tps_pkg.sv =====
// Shared types and constants for the triangle plane splitter.
`timescale 1ns / 1ps
package tps_pkg;
    localparam int CoordW = 32;
    localparam int DistW  = 68;
    localparam int QW     = 33;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DistW-1:0]  t_dist;

    // register indexes
    localparam logic [2:0] RegOx = 3'd0;
    localparam logic [2:0] RegOy = 3'd1;
    localparam logic [2:0] RegOz = 3'd2;
    localparam logic [2:0] RegNx = 3'd3;
    localparam logic [2:0] RegNy = 3'd4;
    localparam logic [2:0] RegNz = 3'd5;

    // datapath commands from the controller
    typedef struct packed {
        logic       load;      // capture input triangle
        logic       mul_en;    // one product of the plane value
        logic [1:0] mul_v;     // vertex index
        logic [1:0] mul_k;     // axis index
        logic       mul_clr;   // clear accumulator
        logic       d_store;   // store accumulator to d[mul_v]
        logic       div_start; // start a division
        logic       div_seg;   // 0: seg maj2->lone, 1: lone->maj1
        logic       div_step;  // one quotient bit
        logic       lerp_en;   // one interpolation product
        logic [1:0] lerp_k;
        logic       classify;  // evaluate signs, pick roles
        logic       out_load;  // load output register
        logic [1:0] out_sel;   // which result
    } t_cmd;

    typedef struct packed {
        logic split;           // triangle crosses plane
    } t_stat;
endpackage

// ===== hdl/tps_datapath.sv =====
// Datapath: plane values, serial divider, interpolation and output register.
`timescale 1ns / 1ps
module tps_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tps_pkg::t_cmd          i_cmd,
    output tps_pkg::t_stat         o_stat,
    input  tps_pkg::t_coord        i_cfg [6],
    input  tps_pkg::t_coord        i_vin [9],
    output tps_pkg::t_coord        o_vout [9],
    output logic                   o_side,
    output logic                   o_split,
    output logic                   o_last
);
    import tps_pkg::*;

    t_coord r_v [3][3];
    t_dist  r_d [3];
    t_dist  r_acc;
    logic   r_held_neg;
    logic   r_split;
    logic [1:0] r_maj1, r_maj2, r_lone;
    logic   r_maj_side;
    // divider
    logic [DistW-1:0] r_rem, r_den;
    logic [QW-1:0]    r_q;
    logic [5:0]       r_cnt;
    // intersection points
    logic signed [CoordW+1:0] r_p [2][3];
    logic signed [DistW-1:0]  r_prod;
    logic [1:0]  r_prod_k;
    logic        r_prod_v;
    logic        r_seg;
    t_coord r_out [9];
    logic   r_side, r_osplit, r_olast;

    // plane value product
    logic signed [CoordW:0]     w_diff;
    logic signed [2*CoordW:0]   w_mul;
    always_comb begin
        w_diff = 33'(r_v[i_cmd.mul_v][i_cmd.mul_k]) - 33'(i_cfg[i_cmd.mul_k]);
        w_mul  = 65'(i_cfg[3'd3 + {1'b0, i_cmd.mul_k}]) * 65'(w_diff);
    end

    // signs
    logic [2:0] w_pos, w_neg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_neg[i] = r_d[i][DistW-1];
            w_pos[i] = !w_neg[i] && (r_d[i] != '0);
        end
    end
    logic w_x01, w_x02, w_x12;
    assign w_x01 = (w_pos[0] && w_neg[1]) || (w_neg[0] && w_pos[1]);
    assign w_x02 = (w_pos[0] && w_neg[2]) || (w_neg[0] && w_pos[2]);
    assign w_x12 = (w_pos[1] && w_neg[2]) || (w_neg[1] && w_pos[2]);

    // segment ends for division
    logic [1:0] w_s0, w_s1;
    assign w_s0 = i_cmd.div_seg ? r_lone : r_maj2;
    assign w_s1 = i_cmd.div_seg ? r_maj1 : r_lone;
    logic [DistW-1:0] w_a0, w_a1;
    assign w_a0 = r_d[w_s0][DistW-1] ? -r_d[w_s0] : r_d[w_s0];
    assign w_a1 = r_d[w_s1][DistW-1] ? -r_d[w_s1] : r_d[w_s1];

    // divider step
    logic [DistW:0] w_sh;
    logic           w_ge;
    assign w_sh = (r_cnt == 6'd0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_ge = w_sh >= {1'b0, r_den};

    // interpolation ends
    logic [1:0] w_e0, w_e1;
    assign w_e0 = r_seg ? r_lone : r_maj2;
    assign w_e1 = r_seg ? r_maj1 : r_lone;
    logic signed [CoordW:0] w_dl;
    logic signed [DistW-1:0] w_lmul;
    assign w_dl = 33'(r_v[w_e1][i_cmd.lerp_k]) - 33'(r_v[w_e0][i_cmd.lerp_k]);
    assign w_lmul = 68'(w_dl) * 68'($signed({1'b0, r_q}));

    function automatic t_coord sat(input logic signed [CoordW+1:0] x);
        if (x > 34'sd2147483647) return 32'h7FFFFFFF;
        if (x < -34'sd2147483648) return 32'h80000000;
        return x[CoordW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_neg <= 1'b0;
            r_split    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                for (int i = 0; i < 3; i++)
                    for (int k = 0; k < 3; k++)
                        r_v[i][k] <= i_vin[i*3 + k];
            end
            if (i_cmd.mul_en) begin
                r_acc <= (i_cmd.mul_clr ? '0 : r_acc) + 68'(w_mul);
            end
            if (i_cmd.d_store) r_d[i_cmd.mul_v] <= r_acc;
            if (i_cmd.classify) begin
                logic h;
                h = r_held_neg;
                for (int i = 0; i < 3; i++)
                    if (w_pos[i] || w_neg[i]) h = w_neg[i];
                r_split <= w_x01 || w_x02 || w_x12;
                if (w_x01 || w_x02 || w_x12) begin
                    r_held_neg <= 1'b0;
                    if (w_x01) begin
                        if (w_x12) begin
                            r_maj1 <= 2'd2; r_maj2 <= 2'd0; r_lone <= 2'd1;
                            r_maj_side <= (w_pos[2]||w_neg[2]) ? !w_neg[2] : !w_neg[0];
                        end else begin
                            r_maj1 <= 2'd1; r_maj2 <= 2'd2; r_lone <= 2'd0;
                            r_maj_side <= (w_pos[1]||w_neg[1]) ? !w_neg[1] : !w_neg[2];
                        end
                    end else begin
                        r_maj1 <= 2'd0; r_maj2 <= 2'd1; r_lone <= 2'd2;
                        r_maj_side <= (w_pos[0]||w_neg[0]) ? !w_neg[0] : !w_neg[1];
                    end
                end else begin
                    r_held_neg <= h;
                    r_maj_side <= !h;
                end
            end
            if (i_cmd.div_start) begin
                r_rem <= w_a0;
                r_den <= w_a0 + w_a1;
                r_q   <= '0;
                r_cnt <= '0;
                r_seg <= i_cmd.div_seg;
            end else if (i_cmd.div_step) begin
                r_rem <= w_ge ? DistW'(w_sh - {1'b0, r_den}) : DistW'(w_sh);
                r_q   <= {r_q[QW-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            // interpolation product, then add
            r_prod   <= w_lmul;
            r_prod_k <= i_cmd.lerp_k;
            r_prod_v <= i_cmd.lerp_en;
            if (r_prod_v)
                r_p[r_seg][r_prod_k] <= 34'(r_v[w_e0][r_prod_k])
                                        + 34'(r_prod[DistW-1:32]);
            if (i_cmd.out_load) begin
                r_osplit <= r_split;
                unique case (i_cmd.out_sel)
                    2'd0: begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_split) begin
                                r_out[k]   <= r_v[r_maj1][k];
                                r_out[3+k] <= r_v[r_maj2][k];
                                r_out[6+k] <= sat(r_p[0][k]);
                            end else begin
                                r_out[k]   <= r_v[0][k];
                                r_out[3+k] <= r_v[1][k];
                                r_out[6+k] <= r_v[2][k];
                            end
                        end
                        r_side  <= r_maj_side;
                        r_olast <= !r_split;
                    end
                    2'd1: begin
                        for (int k = 0; k < 3; k++) begin
                            r_out[k]   <= r_v[r_maj1][k];
                            r_out[3+k] <= sat(r_p[0][k]);
                            r_out[6+k] <= sat(r_p[1][k]);
                        end
                        r_side  <= r_maj_side;
                        r_olast <= 1'b0;
                    end
                    default: begin
                        for (int k = 0; k < 3; k++) begin
                            r_out[k]   <= sat(r_p[1][k]);
                            r_out[3+k] <= sat(r_p[0][k]);
                            r_out[6+k] <= r_v[r_lone][k];
                        end
                        r_side  <= !r_maj_side;
                        r_olast <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_stat.split = r_split;
    assign o_vout  = r_out;
    assign o_side  = r_side;
    assign o_split = r_osplit;
    assign o_last  = r_olast;
endmodule

// ===== hdl/tps_ctrl.sv =====
// Controller: sequences plane values, divisions, interpolation and output.
`timescale 1ns / 1ps
module tps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tps_pkg::t_cmd  o_cmd,
    input  tps_pkg::t_stat i_stat
);
    import tps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_STORE, S_CLASS, S_DSTART, S_DIV, S_LERP, S_LWAIT,
        S_OUT, S_HOLD
    } t_state;

    t_state     r_state;
    logic [1:0] r_v, r_k;
    logic       r_seg;
    logic [5:0] r_cnt;
    logic [1:0] r_osel;
    logic       r_ovalid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_en  = (r_state == S_MUL);
        o_cmd.mul_v   = r_v;
        o_cmd.mul_k   = r_k;
        o_cmd.mul_clr = (r_k == 2'd0);
        o_cmd.d_store = (r_state == S_STORE);
        o_cmd.classify  = (r_state == S_CLASS);
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.div_seg   = r_seg;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.lerp_en   = (r_state == S_LERP);
        o_cmd.lerp_k    = r_k;
        o_cmd.out_load  = (r_state == S_OUT);
        o_cmd.out_sel   = r_osel;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v      <= '0;
            r_k      <= '0;
            r_seg    <= 1'b0;
            r_cnt    <= '0;
            r_osel   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_state <= S_MUL; r_v <= '0; r_k <= '0;
                end
                S_MUL: begin
                    if (r_k == 2'd2) begin r_k <= '0; r_state <= S_STORE; end
                    else r_k <= r_k + 2'd1;
                end
                S_STORE: begin
                    if (r_v == 2'd2) r_state <= S_CLASS;
                    else begin r_v <= r_v + 2'd1; r_state <= S_MUL; end
                end
                S_CLASS: begin
                    r_seg <= 1'b0; r_osel <= '0; r_state <= S_DSTART;
                end
                S_DSTART: begin
                    if (!i_stat.split) r_state <= S_OUT;
                    else begin r_cnt <= '0; r_state <= S_DIV; end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin r_k <= '0; r_state <= S_LERP; end
                end
                S_LERP: begin
                    if (r_k == 2'd2) begin r_k <= '0; r_state <= S_LWAIT; end
                    else r_k <= r_k + 2'd1;
                end
                S_LWAIT: begin
                    if (!r_seg) begin r_seg <= 1'b1; r_state <= S_DSTART; end
                    else r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1; r_state <= S_HOLD;
                end
                S_HOLD: if (i_out_ready) begin
                    r_ovalid <= 1'b0;
                    if (!i_stat.split || r_osel == 2'd2) r_state <= S_IDLE;
                    else begin r_osel <= r_osel + 2'd1; r_state <= S_OUT; end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/triangle_plane_splitter.sv =====
// Top level: configuration registers, controller and datapath.
// A triangle that passes gives one result, a split triangle three. A new
// triangle is accepted only after the last result has been taken, and an
// output stall holds the controller. A split triangle runs two 33-step serial
// divisions through the shared divider. Reset (synchronous, active low)
// clears control, held side and restores the plane registers to origin 0
// and normal (0, 0, 1.0).
`timescale 1ns / 1ps
module triangle_plane_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [31:0] i_a_x, i_a_y, i_a_z,
    input  logic signed [31:0] i_b_x, i_b_y, i_b_z,
    input  logic signed [31:0] i_c_x, i_c_y, i_c_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_out_a_x, o_out_a_y, o_out_a_z,
    output logic signed [31:0] o_out_b_x, o_out_b_y, o_out_b_z,
    output logic signed [31:0] o_out_c_x, o_out_c_y, o_out_c_z,
    output logic        o_side,
    output logic        o_was_split,
    output logic        o_last
);
    import tps_pkg::*;

    t_coord r_cfg [6];
    t_coord w_vin [9];
    t_coord w_vout [9];
    t_cmd   w_cmd;
    t_stat  w_stat;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[RegOx] <= '0;
            r_cfg[RegOy] <= '0;
            r_cfg[RegOz] <= '0;
            r_cfg[RegNx] <= '0;
            r_cfg[RegNy] <= '0;
            r_cfg[RegNz] <= 32'sd65536;
        end else if (psel && penable && pwrite) begin
            if (w_idx <= RegNz) r_cfg[w_idx] <= pwdata;
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        if (w_idx <= RegNz) prdata = r_cfg[w_idx];
    end

    assign w_vin = '{i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z};

    tps_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_valid), .o_in_ready (o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .o_cmd (w_cmd), .i_stat (w_stat)
    );

    tps_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd (w_cmd), .o_stat (w_stat),
        .i_cfg (r_cfg), .i_vin (w_vin), .o_vout (w_vout),
        .o_side (o_side), .o_split (o_was_split), .o_last (o_last)
    );

    assign o_out_a_x = w_vout[0];
    assign o_out_a_y = w_vout[1];
    assign o_out_a_z = w_vout[2];
    assign o_out_b_x = w_vout[3];
    assign o_out_b_y = w_vout[4];
    assign o_out_b_z = w_vout[5];
    assign o_out_c_x = w_vout[6];
    assign o_out_c_y = w_vout[7];
    assign o_out_c_z = w_vout[8];
endmodule
